[hdl/cpsplit_pkg.sv]
// shared types and constants for the command line pipe splitter
package cpsplit_pkg;

  localparam int CMD_W   = 4;
  localparam int EXE_W   = 7;
  localparam int ARG_W   = 9;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  localparam int RES_MAX = 3;

  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] PIPE_BYTE  = 8'h7c;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_EXE  = 2'd1,
    PH_GAP  = 2'd2,
    PH_ARGS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_TOO_BIG  = 2'd2
  } status_t;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;
  localparam logic PART_EXE    = 1'b0;
  localparam logic PART_ARGS   = 1'b1;

  typedef struct packed {
    logic       item_kind;
    logic [2:0] command_index;
    logic       part;
    logic [7:0] out_char;
    logic [1:0] status;
    logic [3:0] command_count;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } result_group_t;

endpackage

[hdl/cpsplit_parser.sv]
// per-byte parse state and result generation
module cpsplit_parser #(
  parameter int MAX_COMMANDS = 8,
  parameter int MAX_EXE_LEN  = 64,
  parameter int MAX_ARG_LEN  = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  in_byte,
  input  logic                        end_of_line,
  output cpsplit_pkg::result_group_t  group
);

  cpsplit_pkg::phase_t            phase, phase_next;
  logic [cpsplit_pkg::CMD_W-1:0]  cmd, cmd_next;
  logic [cpsplit_pkg::EXE_W-1:0]  exe_len, exe_len_next;
  logic [cpsplit_pkg::ARG_W-1:0]  arg_len, arg_len_next;
  logic                           space_pend, space_pend_next;
  logic                           seg_nonempty, seg_nonempty_next;
  logic [1:0]                     err, err_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= cpsplit_pkg::PH_LEAD;
      cmd          <= '0;
      exe_len      <= '0;
      arg_len      <= '0;
      space_pend   <= 1'b0;
      seg_nonempty <= 1'b0;
      err          <= cpsplit_pkg::ST_OK;
    end else if (accept) begin
      phase        <= phase_next;
      cmd          <= cmd_next;
      exe_len      <= exe_len_next;
      arg_len      <= arg_len_next;
      space_pend   <= space_pend_next;
      seg_nonempty <= seg_nonempty_next;
      err          <= err_next;
    end
  end

  always_comb begin
    logic                           ws;
    logic                           do_exe;
    logic                           do_arg;
    logic [cpsplit_pkg::ARG_W:0]    arg_need;
    logic [1:0]                     n;
    cpsplit_pkg::result_t           res [cpsplit_pkg::RES_MAX];
    cpsplit_pkg::result_t           blank;

    phase_next        = phase;
    cmd_next          = cmd;
    exe_len_next      = exe_len;
    arg_len_next      = arg_len;
    space_pend_next   = space_pend;
    seg_nonempty_next = seg_nonempty;
    err_next          = err;
    ws     = (in_byte == cpsplit_pkg::SPACE_BYTE) || (in_byte == cpsplit_pkg::TAB_BYTE);
    do_exe = 1'b0;
    do_arg = 1'b0;
    n      = 2'd0;
    blank  = '0;
    for (int i = 0; i < cpsplit_pkg::RES_MAX; i++) begin
      res[i] = blank;
    end
    arg_need = {1'b0, arg_len} + (space_pend ? (cpsplit_pkg::ARG_W+1)'(2)
                                             : (cpsplit_pkg::ARG_W+1)'(1));

    if (err == cpsplit_pkg::ST_OK) begin
      if (in_byte == cpsplit_pkg::PIPE_BYTE) begin
        if (seg_nonempty) begin
          cmd_next = cmd + 1'b1;
        end
        phase_next        = cpsplit_pkg::PH_LEAD;
        exe_len_next      = '0;
        arg_len_next      = '0;
        space_pend_next   = 1'b0;
        seg_nonempty_next = 1'b0;
      end else begin
        unique case (phase)
          cpsplit_pkg::PH_LEAD: begin
            if (in_byte != cpsplit_pkg::SPACE_BYTE) begin
              if (cmd >= cpsplit_pkg::CMD_W'(MAX_COMMANDS)) begin
                err_next = cpsplit_pkg::ST_TOO_MANY;
              end else begin
                seg_nonempty_next = 1'b1;
                phase_next        = cpsplit_pkg::PH_EXE;
                do_exe            = 1'b1;
              end
            end
          end
          cpsplit_pkg::PH_EXE: begin
            if (in_byte == cpsplit_pkg::SPACE_BYTE) begin
              phase_next = cpsplit_pkg::PH_GAP;
            end else begin
              do_exe = 1'b1;
            end
          end
          cpsplit_pkg::PH_GAP: begin
            if (!ws) begin
              phase_next = cpsplit_pkg::PH_ARGS;
              do_arg     = 1'b1;
            end
          end
          cpsplit_pkg::PH_ARGS: begin
            if (ws) begin
              space_pend_next = 1'b1;
            end else begin
              do_arg = 1'b1;
            end
          end
          default: begin
            phase_next = cpsplit_pkg::PH_LEAD;
          end
        endcase
      end
    end

    if (do_exe) begin
      if (exe_len >= cpsplit_pkg::EXE_W'(MAX_EXE_LEN)) begin
        err_next = cpsplit_pkg::ST_TOO_BIG;
      end else begin
        res[n].item_kind     = cpsplit_pkg::KIND_CHAR;
        res[n].command_index = cmd[2:0];
        res[n].part          = cpsplit_pkg::PART_EXE;
        res[n].out_char      = in_byte;
        n                    = n + 2'd1;
        exe_len_next         = exe_len + 1'b1;
      end
    end

    if (do_arg) begin
      if (arg_need > (cpsplit_pkg::ARG_W+1)'(MAX_ARG_LEN)) begin
        err_next = cpsplit_pkg::ST_TOO_BIG;
      end else begin
        if (space_pend) begin
          res[n].item_kind     = cpsplit_pkg::KIND_CHAR;
          res[n].command_index = cmd[2:0];
          res[n].part          = cpsplit_pkg::PART_ARGS;
          res[n].out_char      = cpsplit_pkg::SPACE_BYTE;
          n                    = n + 2'd1;
          space_pend_next      = 1'b0;
        end
        res[n].item_kind     = cpsplit_pkg::KIND_CHAR;
        res[n].command_index = cmd[2:0];
        res[n].part          = cpsplit_pkg::PART_ARGS;
        res[n].out_char      = in_byte;
        n                    = n + 2'd1;
        arg_len_next         = arg_need[cpsplit_pkg::ARG_W-1:0];
      end
    end

    if (end_of_line) begin
      res[n].item_kind     = cpsplit_pkg::KIND_REPORT;
      res[n].status        = err_next;
      res[n].command_count = cmd_next + {3'b000, seg_nonempty_next};
      res[n].last          = 1'b1;
      n                    = n + 2'd1;
      phase_next           = cpsplit_pkg::PH_LEAD;
      cmd_next             = '0;
      exe_len_next         = '0;
      arg_len_next         = '0;
      space_pend_next      = 1'b0;
      seg_nonempty_next    = 1'b0;
      err_next             = cpsplit_pkg::ST_OK;
    end

    group.count = n;
    group.r0    = res[0];
    group.r1    = res[1];
    group.r2    = res[2];
  end

endmodule

[hdl/cpsplit_queue.sv]
// result queue taking up to three entries per cycle, one beat out per cycle unless out_stall
module cpsplit_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  cpsplit_pkg::result_group_t  group,
  output logic                        room,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cpsplit_pkg::result_t        head_item
);

  cpsplit_pkg::result_t                 entries [cpsplit_pkg::Q_DEPTH];
  logic [cpsplit_pkg::Q_PTR_W-1:0]      head, head_next;
  logic [cpsplit_pkg::Q_PTR_W-1:0]      tail, tail_next;
  logic [cpsplit_pkg::Q_CNT_W-1:0]      count, count_next;
  logic                                 pop;
  logic [1:0]                           n_in;

  assign n_in      = push ? group.count : 2'd0;
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= cpsplit_pkg::Q_CNT_W'(cpsplit_pkg::Q_DEPTH - cpsplit_pkg::RES_MAX));
  assign head_item = entries[head];

  always_comb begin
    head_next  = head + (pop ? cpsplit_pkg::Q_PTR_W'(1) : '0);
    tail_next  = tail + cpsplit_pkg::Q_PTR_W'(n_in);
    count_next = count + cpsplit_pkg::Q_CNT_W'(n_in)
                 - (pop ? cpsplit_pkg::Q_CNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in > 2'd0) begin
      entries[tail] <= group.r0;
    end
    if (n_in > 2'd1) begin
      entries[tail + cpsplit_pkg::Q_PTR_W'(1)] <= group.r1;
    end
    if (n_in > 2'd2) begin
      entries[tail + cpsplit_pkg::Q_PTR_W'(2)] <= group.r2;
    end
  end

endmodule

[hdl/command_line_pipe_splitter.sv]
// top level of the command line pipe splitter
// Usage: feed the command line one byte per beat on the input channel
// (in_valid, in_stall, in_byte, end_of_line), with end_of_line high on the
// final byte. Each kept character leaves as one beat on the output channel
// (out_valid, out_stall, item_kind and the other result fields), tagged with
// its command index and part; after the final byte a report beat follows
// with status and command count, and last high.
// The results of a byte are written into the result queue when it is accepted.
// Throughput: one byte per cycle while out_stall is low and each byte
// makes at most one beat; a byte making two or three beats (owed space,
// character, report) holds the input for the extra cycles needed to drain
// the four-entry result queue, which sets the rate.
// in_stall is high while the queue cannot take three more beats, so a
// stalled receiver backs up into the input without losing anything.
// Reset (rst, synchronous) empties the queue and returns the parser to the
// start of a line.
module command_line_pipe_splitter #(
  parameter int MAX_COMMANDS = 8,
  parameter int MAX_EXE_LEN  = 64,
  parameter int MAX_ARG_LEN  = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       item_kind,
  output logic [2:0] command_index,
  output logic       part,
  output logic [7:0] out_char,
  output logic [1:0] status,
  output logic [3:0] command_count,
  output logic       last
);

  cpsplit_pkg::result_group_t group;
  cpsplit_pkg::result_t       head_item;
  logic                       room;
  logic                       accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  cpsplit_parser #(
    .MAX_COMMANDS (MAX_COMMANDS),
    .MAX_EXE_LEN  (MAX_EXE_LEN),
    .MAX_ARG_LEN  (MAX_ARG_LEN)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_line (end_of_line),
    .group       (group)
  );

  cpsplit_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .group     (group),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_item (head_item)
  );

  assign item_kind     = head_item.item_kind;
  assign command_index = head_item.command_index;
  assign part          = head_item.part;
  assign out_char      = head_item.out_char;
  assign status        = head_item.status;
  assign command_count = head_item.command_count;
  assign last          = head_item.last;

endmodule
